// ----- hw/rtl/nge_pkg.sv -----
// Shared constants, widths, opcodes and types for the next greater element engine.
package nge_pkg;

  localparam int DATA_W      = 32;
  localparam int STACK_DEPTH = 256;
  localparam int TABLE_DEPTH = 256;

  localparam int SAW = $clog2(STACK_DEPTH);     // stack address width
  localparam int SCW = $clog2(STACK_DEPTH + 1); // stack fill count width
  localparam int TAW = $clog2(TABLE_DEPTH);     // table address width
  localparam int TCW = $clog2(TABLE_DEPTH + 1); // table fill count width

  localparam logic [DATA_W-1:0] NOT_FOUND = '1;

  typedef enum logic [1:0] {
    OP_SEQ   = 2'd0,
    OP_QUERY = 2'd1,
    OP_CLEAR = 2'd2
  } opcode_t;

  typedef struct packed {
    logic gt;
    logic eq;
  } cmp_res_t;

endpackage

// ----- hw/rtl/nge_ram.sv -----
// Single-port RAM with registered read data.
module nge_ram #(
  parameter int DEPTH = 256,
  parameter int WIDTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata_r <= mem[addr];
  end

  assign rdata = rdata_r;

endmodule

// ----- hw/rtl/nge_cmp.sv -----
// Shared compare unit: signed greater-than and equality of two words.
module nge_cmp (
  input  logic signed [nge_pkg::DATA_W-1:0] a,
  input  logic signed [nge_pkg::DATA_W-1:0] b,
  output nge_pkg::cmp_res_t                 res
);
  import nge_pkg::*;

  always_comb begin
    res.gt = (a > b);
    res.eq = (a == b);
  end

endmodule

// ----- hw/rtl/next_greater_element_engine.sv -----
// Top level: sequencer, stack and table memories around one shared compare unit.
//
//   channel | ports                                   | direction
//   --------+-----------------------------------------+----------
//   in      | in_valid, in_ready, in_opcode, in_value | into block
//   out     | out_valid, out_ready, out_found,        | out of block
//           | out_next_greater, out_overflow          |
//
// Steps: a clear or an unused opcode is handled when accepted. A query reads table
// entries up to and including a hit (at most the fill count), then loads the result.
// A sequence word is accepted, then each stack top is compared with it and, for each
// pop, the table is searched; when a top is not smaller or the stack runs empty, the
// word is pushed. The table search reads one key per cycle through the single key
// RAM port and the shared comparator.
// Reset: synchronous, active low; clears both fill counts and the overflow flag.
// The memories hold no reset value, and no word beyond the fill counts is ever used.
// Stalls: in_ready is high only while the sequencer is idle; a result waits in the
// output register, and the next word may be taken while it waits.
module next_greater_element_engine (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [1:0]                       in_opcode,
  input  logic signed [nge_pkg::DATA_W-1:0] in_value,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic                             out_found,
  output logic signed [nge_pkg::DATA_W-1:0] out_next_greater,
  output logic                             out_overflow
);
  import nge_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_POP_CHK,
    S_POP_WAIT,
    S_SRCH,
    S_PUSH,
    S_RESULT
  } state_t;

  state_t            state_r;
  logic              query_r;      // current word is a query, not a sequence element
  logic [DATA_W-1:0] val_r;        // incoming value
  logic [DATA_W-1:0] top_r;        // stack top being popped
  logic [SCW-1:0]    scount_r;
  logic [TCW-1:0]    tcount_r;
  logic              ovf_r;
  logic [TCW-1:0]    idx_r;        // next table address to read
  logic              pend_r;       // key read data is valid for hit_idx_r
  logic [TAW-1:0]    hit_idx_r;    // table address of the key now on the RAM output
  logic              res_found_r;
  logic [DATA_W-1:0] res_next_r;
  logic              out_valid_r;
  logic              out_found_r;
  logic [DATA_W-1:0] out_next_r;
  logic              out_ovf_r;

  logic              stk_we;
  logic [SAW-1:0]    stk_addr;
  logic [DATA_W-1:0] stk_q;
  logic              key_we;
  logic              next_we;
  logic [TAW-1:0]    tbl_addr;
  logic [DATA_W-1:0] key_q;
  logic [DATA_W-1:0] next_q;
  logic [DATA_W-1:0] cmp_a;
  logic [DATA_W-1:0] cmp_b;
  cmp_res_t          cmp;
  logic [SCW-1:0]    stk_top_idx;
  logic              hit;
  logic              srch_end;
  logic              stk_room;
  logic              tbl_room;

  // Memories
  nge_ram #(.DEPTH(STACK_DEPTH), .WIDTH(DATA_W)) u_stack (
    .clk   (clk),
    .we    (stk_we),
    .addr  (stk_addr),
    .wdata (val_r),
    .rdata (stk_q)
  );

  nge_ram #(.DEPTH(TABLE_DEPTH), .WIDTH(DATA_W)) u_key (
    .clk   (clk),
    .we    (key_we),
    .addr  (tbl_addr),
    .wdata (top_r),
    .rdata (key_q)
  );

  nge_ram #(.DEPTH(TABLE_DEPTH), .WIDTH(DATA_W)) u_next (
    .clk   (clk),
    .we    (next_we),
    .addr  (tbl_addr),
    .wdata (val_r),
    .rdata (next_q)
  );

  // One comparator serves both the pop test (greater) and the table search (equal).
  nge_cmp u_cmp (
    .a   (cmp_a),
    .b   (cmp_b),
    .res (cmp)
  );

  // Search target is the popped top for a record, the queried value otherwise.
  assign cmp_a = (state_r == S_SRCH && !query_r) ? top_r : val_r;
  assign cmp_b = (state_r == S_SRCH) ? key_q : stk_q;

  always_comb begin
    stk_top_idx = scount_r - SCW'(1);
    stk_room    = (scount_r < SCW'(STACK_DEPTH));
    tbl_room    = (tcount_r < TCW'(TABLE_DEPTH));
    hit         = pend_r && cmp.eq;
    srch_end    = (idx_r == tcount_r);

    stk_we   = 1'b0;
    stk_addr = scount_r[SAW-1:0];
    key_we   = 1'b0;
    next_we  = 1'b0;
    tbl_addr = idx_r[TAW-1:0];

    case (state_r)
      S_POP_CHK: begin
        stk_addr = stk_top_idx[SAW-1:0];
      end
      S_PUSH: begin
        stk_we = stk_room;
      end
      S_SRCH: begin
        if (hit) begin
          // Overwrite the recorded next greater value in place.
          tbl_addr = hit_idx_r;
          next_we  = !query_r;
        end else if (srch_end) begin
          // Append a new key, or drop it when the table is full.
          tbl_addr = tcount_r[TAW-1:0];
          key_we   = !query_r && tbl_room;
          next_we  = !query_r && tbl_room;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      scount_r    <= '0;
      tcount_r    <= '0;
      ovf_r       <= 1'b0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      // Drop the result once taken, unless a new one is loaded this cycle.
      if (out_valid_r && out_ready && state_r != S_RESULT) begin
        out_valid_r <= 1'b0;
      end

      case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            val_r <= in_value;
            case (opcode_t'(in_opcode))
              OP_SEQ: begin
                query_r <= 1'b0;
                state_r <= S_POP_CHK;
              end
              OP_QUERY: begin
                query_r <= 1'b1;
                idx_r   <= '0;
                pend_r  <= 1'b0;
                state_r <= S_SRCH;
              end
              OP_CLEAR: begin
                scount_r <= '0;
                tcount_r <= '0;
                ovf_r    <= 1'b0;
              end
              default: begin
                // unused opcode: drop the word
              end
            endcase
          end
        end

        S_POP_CHK: begin
          // Empty stack: nothing left to pop, go and push.
          state_r <= (scount_r == '0) ? S_PUSH : S_POP_WAIT;
        end

        S_POP_WAIT: begin
          if (cmp.gt) begin
            top_r   <= stk_q;
            idx_r   <= '0;
            pend_r  <= 1'b0;
            state_r <= S_SRCH;
          end else begin
            state_r <= S_PUSH;
          end
        end

        S_SRCH: begin
          if (hit || srch_end) begin
            pend_r <= 1'b0;
            if (query_r) begin
              res_found_r <= hit;
              res_next_r  <= hit ? next_q : NOT_FOUND;
              state_r     <= S_RESULT;
            end else begin
              if (!hit) begin
                if (tbl_room) begin
                  tcount_r <= tcount_r + TCW'(1);
                end else begin
                  ovf_r <= 1'b1;
                end
              end
              scount_r <= stk_top_idx;
              state_r  <= S_POP_CHK;
            end
          end else begin
            // Issue the next key read; compare it next cycle.
            hit_idx_r <= idx_r[TAW-1:0];
            idx_r     <= idx_r + TCW'(1);
            pend_r    <= 1'b1;
          end
        end

        S_PUSH: begin
          if (stk_room) begin
            scount_r <= scount_r + SCW'(1);
          end else begin
            ovf_r <= 1'b1;
          end
          state_r <= S_IDLE;
        end

        S_RESULT: begin
          // Hold until the output register is free.
          if (!out_valid_r || out_ready) begin
            out_valid_r <= 1'b1;
            out_found_r <= res_found_r;
            out_next_r  <= res_next_r;
            out_ovf_r   <= ovf_r;
            state_r     <= S_IDLE;
          end
        end

        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign in_ready         = (state_r == S_IDLE);
  assign out_valid        = out_valid_r;
  assign out_found        = out_found_r;
  assign out_next_greater = out_next_r;
  assign out_overflow     = out_ovf_r;

  // Fill counts never pass their capacity.
  a_stack_bound: assert property (@(posedge clk) disable iff (!rst_n)
    scount_r <= SCW'(STACK_DEPTH))
    else $error("stack fill count beyond depth");

  a_table_bound: assert property (@(posedge clk) disable iff (!rst_n)
    tcount_r <= TCW'(TABLE_DEPTH))
    else $error("table fill count beyond depth");

  // A clear word empties both stores and drops overflow.
  a_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && in_opcode == OP_CLEAR) |=>
      (scount_r == '0 && tcount_r == '0 && !ovf_r))
    else $error("clear did not empty the stores");

  // A miss always reports the not-found code.
  a_miss_code: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_found) |-> (out_next_greater == NOT_FOUND))
    else $error("miss without not-found code");

endmodule
